[rtl/core/hpec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hpec_pkg;

   localparam int GAP_W     = 6;
   localparam logic [GAP_W-1:0] GAP_MAX = 6'd63;
   localparam int N_GAPS    = 9;
   localparam int ROW_SLOTS = 18;
   localparam int IDX_W     = $clog2(ROW_SLOTS);
   localparam int DILATIONS = 3;
   localparam int DIL_W     = $clog2(DILATIONS + 1);
   localparam int PV_W      = 10;   // partition parts
   localparam int BND_W     = 12;   // hive boundary entries
   localparam int RHS_W     = 15;   // row constants
   localparam int CRD_W     = 12;   // dilated u, v coordinates
   localparam int REM_W     = 20;   // row remainders, interval ends
   localparam int CNT_W     = 32;
   localparam int COEF_W    = 38;
   localparam int WIDE_W    = 42;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic signed [WIDE_W-1:0] COEF_LIM = 42'sh10_0000_0000;

   localparam logic [1:0] SLOT_NONE = 2'd3;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NOT_DIV     = 3'd1,
      ST_INFEAS      = 3'd2,
      ST_EMPTY_RANGE = 3'd3,
      ST_EMPTY_POLY  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_BUILD,
      S_CHECK,
      S_START,
      S_FIBRE,
      S_ACC,
      S_FIN,
      S_CLAMP,
      S_OUT
   } state_type;

   typedef logic [3:0][PV_W-1:0] part_type;

   typedef struct packed {
      part_type lam;
      part_type mu;
      part_type nu;
   } parts_type;

   // minus points a, b and plus points c, d of one rhombus
   typedef struct packed {
      logic [2:0] ax, ay, bx, by, cx, cy, dx, dy;
   } pat_type;

   typedef struct packed {
      logic signed [3:0] s;
      logic signed [2:0] q;
      logic signed [2:0] r;
      logic              has_int;
   } coef_type;

   typedef struct packed {
      logic signed [REM_W-1:0] lo;
      logic signed [REM_W-1:0] hi;
      logic                    lo_inf;
      logic                    hi_inf;
      logic                    ok;
   } track_type;

   function automatic pat_type pat_at(logic [IDX_W-1:0] idx);
      pat_type p;
      case (idx)
         5'd0:    p = '{3'd1, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1};
         5'd1:    p = '{3'd1, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd1, 3'd2};
         5'd2:    p = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0};
         5'd3:    p = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd0, 3'd2, 3'd1, 3'd3};
         5'd4:    p = '{3'd0, 3'd2, 3'd1, 3'd2, 3'd0, 3'd3, 3'd1, 3'd1};
         5'd5:    p = '{3'd0, 3'd3, 3'd1, 3'd3, 3'd0, 3'd4, 3'd1, 3'd2};
         5'd6:    p = '{3'd2, 3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd2, 3'd1};
         5'd7:    p = '{3'd1, 3'd0, 3'd1, 3'd1, 3'd2, 3'd0, 3'd0, 3'd1};
         5'd8:    p = '{3'd2, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2};
         5'd9:    p = '{3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd0};
         5'd10:   p = '{3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd0, 3'd2};
         5'd11:   p = '{3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd3, 3'd2, 3'd1};
         5'd12:   p = '{3'd1, 3'd2, 3'd1, 3'd3, 3'd2, 3'd2, 3'd0, 3'd3};
         5'd13:   p = '{3'd3, 3'd0, 3'd2, 3'd1, 3'd2, 3'd0, 3'd3, 3'd1};
         5'd14:   p = '{3'd2, 3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd1, 3'd1};
         5'd15:   p = '{3'd2, 3'd1, 3'd3, 3'd1, 3'd2, 3'd2, 3'd3, 3'd0};
         5'd16:   p = '{3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd1, 3'd1, 3'd2};
         5'd17:   p = '{3'd3, 3'd0, 3'd3, 3'd1, 3'd4, 3'd0, 3'd2, 3'd1};
         default: p = '0;
      endcase
      return p;
   endfunction

   function automatic logic [1:0] slot_of(logic [2:0] x, logic [2:0] y);
      logic [1:0] sl;
      if (x == 3'd1 && y == 3'd1) begin
         sl = 2'd0;
      end else if (x == 3'd1 && y == 3'd2) begin
         sl = 2'd1;
      end else if (x == 3'd2 && y == 3'd1) begin
         sl = 2'd2;
      end else begin
         sl = SLOT_NONE;
      end
      return sl;
   endfunction

   function automatic logic signed [2:0] tally(logic [1:0] id, logic [1:0] sa,
                                               logic [1:0] sb, logic [1:0] sc,
                                               logic [1:0] sd);
      logic signed [2:0] t;
      t = 3'sd0;
      if (sc == id) t = t + 3'sd1;
      if (sd == id) t = t + 3'sd1;
      if (sa == id) t = t - 3'sd1;
      if (sb == id) t = t - 3'sd1;
      return t;
   endfunction

   function automatic coef_type pat_coef(pat_type p);
      logic [1:0] sa, sb, sc, sd;
      logic signed [2:0] c0, c1, c2;
      coef_type co;
      sa = slot_of(p.ax, p.ay);
      sb = slot_of(p.bx, p.by);
      sc = slot_of(p.cx, p.cy);
      sd = slot_of(p.dx, p.dy);
      c0 = tally(2'd0, sa, sb, sc, sd);
      c1 = tally(2'd1, sa, sb, sc, sd);
      c2 = tally(2'd2, sa, sb, sc, sd);
      co.s = {c0[2], c0} + {c1[2], c1} + {c2[2], c2};
      co.q = c1;
      co.r = c2;
      co.has_int = (c0 != 3'sd0) || (c1 != 3'sd0) || (c2 != 3'sd0);
      return co;
   endfunction

endpackage
`default_nettype wire

[rtl/core/hpec_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface hpec_req_if;
   import hpec_pkg::*;
   logic             valid;
   logic             ready;
   logic [GAP_W-1:0] lam_gap_1;
   logic [GAP_W-1:0] lam_gap_2;
   logic [GAP_W-1:0] lam_gap_3;
   logic [GAP_W-1:0] mu_gap_1;
   logic [GAP_W-1:0] mu_gap_2;
   logic [GAP_W-1:0] mu_gap_3;
   logic [GAP_W-1:0] nu_gap_1;
   logic [GAP_W-1:0] nu_gap_2;
   logic [GAP_W-1:0] nu_gap_3;

   modport source (output valid, lam_gap_1, lam_gap_2, lam_gap_3, mu_gap_1, mu_gap_2,
                   mu_gap_3, nu_gap_1, nu_gap_2, nu_gap_3, input ready);
   modport sink (input valid, lam_gap_1, lam_gap_2, lam_gap_3, mu_gap_1, mu_gap_2,
                 mu_gap_3, nu_gap_1, nu_gap_2, nu_gap_3, output ready);
endinterface
`default_nettype wire

[rtl/core/hpec_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface hpec_rsp_if;
   import hpec_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     valid_res;
   logic [2:0]               status;
   logic [CNT_W-1:0]         count_1;
   logic [CNT_W-1:0]         count_2;
   logic [CNT_W-1:0]         count_3;
   logic signed [COEF_W-1:0] six_linear_coeff;
   logic signed [COEF_W-1:0] volume;

   modport source (output valid, valid_res, status, count_1, count_2, count_3,
                   six_linear_coeff, volume, input ready);
   modport sink (input valid, valid_res, status, count_1, count_2, count_3,
                 six_linear_coeff, volume, output ready);
endinterface
`default_nettype wire

[rtl/core/hpec_rowgen.sv]
`timescale 1ns / 1ps
`default_nettype none
module hpec_rowgen (
   input  var hpec_pkg::parts_type                   parts,
   input  var logic [hpec_pkg::IDX_W-1:0]            idx,
   output var logic signed [hpec_pkg::RHS_W-1:0]     rhs,
   output var logic                                  infeas
);
   import hpec_pkg::*;

   typedef logic [4:0][BND_W-1:0] pre_type;

   pre_type lp, mp, np;
   pat_type pat;
   coef_type coef;
   logic signed [RHS_W-1:0] cst;

   // boundary entry of the hive at (x, y)
   function automatic logic signed [RHS_W-1:0] bnd_of(logic [2:0] x, logic [2:0] y,
                                                       pre_type l, pre_type m, pre_type n);
      logic [BND_W-1:0] b;
      if (x == 3'd0) begin
         b = l[y];
      end else if (y == 3'd0) begin
         b = n[x];
      end else begin
         b = l[4] + m[x];
      end
      return $signed(RHS_W'(b));
   endfunction

   function automatic logic signed [RHS_W-1:0] term(logic [2:0] x, logic [2:0] y,
                                                     pre_type l, pre_type m, pre_type n);
      logic signed [RHS_W-1:0] t;
      if (slot_of(x, y) == SLOT_NONE) begin
         t = bnd_of(x, y, l, m, n);
      end else begin
         t = '0;
      end
      return t;
   endfunction

   always_comb begin
      lp[0] = '0;
      mp[0] = '0;
      np[0] = '0;
      for (int i = 0; i < 4; i++) begin
         lp[i+1] = lp[i] + BND_W'(parts.lam[i]);
         mp[i+1] = mp[i] + BND_W'(parts.mu[i]);
         np[i+1] = np[i] + BND_W'(parts.nu[i]);
      end
   end

   always_comb begin
      pat  = pat_at(idx);
      coef = pat_coef(pat);
      cst  = term(pat.cx, pat.cy, lp, mp, np) + term(pat.dx, pat.dy, lp, mp, np)
           - term(pat.ax, pat.ay, lp, mp, np) - term(pat.bx, pat.by, lp, mp, np);
      rhs    = -cst;
      infeas = !coef.has_int && (cst > 0);
   end

endmodule
`default_nettype wire

[rtl/core/hpec_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
module hpec_eval (
   input  var hpec_pkg::coef_type                 coef,
   input  var logic [hpec_pkg::DIL_W-1:0]         dil,
   input  var logic signed [hpec_pkg::RHS_W-1:0]  rhs,
   input  var logic [hpec_pkg::CRD_W-1:0]         u,
   input  var logic [hpec_pkg::CRD_W-1:0]         v,
   input  var hpec_pkg::track_type                cur,
   output var hpec_pkg::track_type                nxt
);
   import hpec_pkg::*;

   logic signed [REM_W-1:0] nrhs, qu, rv, rem, neg;

   always_comb begin
      nrhs = REM_W'(rhs) * $signed(REM_W'(dil));
      qu   = REM_W'(coef.q) * $signed(REM_W'(u));
      rv   = REM_W'(coef.r) * $signed(REM_W'(v));
      rem  = nrhs - qu - rv;
      neg  = -rem;
      nxt  = cur;
      if (coef.has_int) begin
         if (coef.s == 4'sd0) begin
            if (rem < 0) nxt.ok = 1'b0;
         end else if (coef.s > 4'sd0) begin
            if (cur.hi_inf || rem < cur.hi) begin
               nxt.hi     = rem;
               nxt.hi_inf = 1'b0;
            end
         end else begin
            if (cur.lo_inf || neg > cur.lo) begin
               nxt.lo     = neg;
               nxt.lo_inf = 1'b0;
            end
         end
      end
   end

endmodule
`default_nettype wire

[rtl/core/hive_polytope_ehrhart_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// lattice point counter for the hive polytope of three rank-4 partitions
// req_chan carries one item of nine 6-bit gaps (lambda, mu, nu); rsp_chan
// returns one item per request: valid_res, status, the counts at dilations
// one to three, six times the linear coefficient and the normalized volume
// sequence: set up, build the row table (18 rows), then for each dilation
// n = 1..3 and every (u, v) of the dilated range run the 18 rows through
// one shared row evaluator and accumulate the fibre, then form the
// coefficients; the range holds (n*a+1)(n*b+1) points, where a, b are
// the second gaps of lambda and nu
// rejected items (not divisible by 4, infeasible row) skip the dilations
// one item at a time: req_chan.ready is high only while the block is idle
// the result is held on rsp_chan until taken; a stalled receiver holds the
// block, and no new item is accepted before the result leaves
// reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_chan.valid; no clearing pass is needed
module hive_polytope_ehrhart_counter (
   input  wire logic   clock,
   input  wire logic   reset,
   hpec_req_if.sink    req_chan,
   hpec_rsp_if.source  rsp_chan
);
   import hpec_pkg::*;

   state_type state_ff, state_in;

   // accepted gaps
   logic [GAP_W-1:0] g_ff [N_GAPS];
   logic [GAP_W-1:0] g_in [N_GAPS];

   parts_type parts_ff, parts_in;
   logic      infeas_ff, infeas_in;

   // row constants, one per rhombus pattern
   logic signed [RHS_W-1:0] rhs_ff [ROW_SLOTS];
   logic signed [RHS_W-1:0] rhs_in;
   logic                    rhs_we;

   logic [IDX_W-1:0] k_ff, k_in;
   logic [DIL_W-1:0] n_ff, n_in;
   logic [CRD_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [CRD_W-1:0] uhi_ff, uhi_in, vlo_ff, vlo_in, vhi_ff, vhi_in;
   track_type        trk_ff, trk_in, trk_eval;
   logic [CNT_W-1:0] total_ff, total_in;

   // result registers
   logic                     rv_ff, rv_in;
   status_type               st_ff, st_in;
   logic [CNT_W-1:0]         cnt_ff [DILATIONS];
   logic [CNT_W-1:0]         cnt_in [DILATIONS];
   logic signed [WIDE_W-1:0] six_ff, six_in, vol_ff, vol_in;

   // front end arithmetic
   logic [GAP_W-1:0]        gs [N_GAPS];
   logic [8:0]              wa, wb, wc;
   logic signed [10:0]      dd;
   logic signed [8:0]       kq;
   logic [PV_W-1:0]         l4, n4;
   parts_type               parts_calc;

   logic signed [RHS_W-1:0] row_rhs;
   logic                    row_infeas;
   coef_type                coef_k;

   logic signed [REM_W:0]   len;
   logic [CNT_W:0]          sum;
   logic [CNT_W-1:0]        acc_total;
   logic [CRD_W-1:0]        ulo_n, uhi_n, vlo_n, vhi_n;
   logic signed [WIDE_W-1:0] c1w, c2w, c3w;

   hpec_rowgen u_rowgen (
      .parts  (parts_ff),
      .idx    (k_ff),
      .rhs    (row_rhs),
      .infeas (row_infeas)
   );

   assign coef_k = pat_coef(pat_at(k_ff));

   hpec_eval u_eval (
      .coef (coef_k),
      .dil  (n_ff),
      .rhs  (rhs_ff[k_ff]),
      .u    (u_ff),
      .v    (v_ff),
      .cur  (trk_ff),
      .nxt  (trk_eval)
   );

   // saturate gaps, rebuild the partitions from the weighted difference
   always_comb begin
      for (int i = 0; i < N_GAPS; i++) begin
         gs[i] = (g_ff[i] > GAP_MAX) ? GAP_MAX : g_ff[i];
      end
      wa = 9'd3 * 9'(gs[2]) + 9'd2 * 9'(gs[1]) + 9'(gs[0]);
      wb = 9'd3 * 9'(gs[5]) + 9'd2 * 9'(gs[4]) + 9'(gs[3]);
      wc = 9'd3 * 9'(gs[8]) + 9'd2 * 9'(gs[7]) + 9'(gs[6]);
      dd = $signed(11'(wc)) - $signed(11'(wa)) - $signed(11'(wb));
      kq = 9'(dd >>> 2);
      l4 = (kq >= 0) ? PV_W'(kq) : '0;
      n4 = (kq < 0) ? PV_W'(-kq) : '0;
      parts_calc.lam[3] = l4;
      parts_calc.lam[2] = l4 + PV_W'(gs[2]);
      parts_calc.lam[1] = parts_calc.lam[2] + PV_W'(gs[1]);
      parts_calc.lam[0] = parts_calc.lam[1] + PV_W'(gs[0]);
      parts_calc.mu[3]  = '0;
      parts_calc.mu[2]  = PV_W'(gs[5]);
      parts_calc.mu[1]  = parts_calc.mu[2] + PV_W'(gs[4]);
      parts_calc.mu[0]  = parts_calc.mu[1] + PV_W'(gs[3]);
      parts_calc.nu[3]  = n4;
      parts_calc.nu[2]  = n4 + PV_W'(gs[8]);
      parts_calc.nu[1]  = parts_calc.nu[2] + PV_W'(gs[7]);
      parts_calc.nu[0]  = parts_calc.nu[1] + PV_W'(gs[6]);
   end

   // dilated ranges and interval accumulation
   always_comb begin
      ulo_n = CRD_W'(n_ff) * CRD_W'(parts_ff.lam[2]);
      uhi_n = CRD_W'(n_ff) * CRD_W'(parts_ff.lam[1]);
      vlo_n = CRD_W'(n_ff) * CRD_W'(parts_ff.nu[2]);
      vhi_n = CRD_W'(n_ff) * CRD_W'(parts_ff.nu[1]);
      len   = $signed({trk_ff.hi[REM_W-1], trk_ff.hi})
            - $signed({trk_ff.lo[REM_W-1], trk_ff.lo}) + 1;
      sum   = {1'b0, total_ff} + (CNT_W+1)'(len);
      acc_total = total_ff;
      if (trk_ff.ok) begin
         if (trk_ff.lo_inf || trk_ff.hi_inf) begin
            // unbounded fibre
            acc_total = CNT_MAX;
         end else if (trk_ff.hi >= trk_ff.lo) begin
            acc_total = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
         end
      end
      c1w = $signed(WIDE_W'(cnt_ff[0]));
      c2w = $signed(WIDE_W'(cnt_ff[1]));
      c3w = $signed(WIDE_W'(cnt_ff[2]));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_chan.valid) state_in = S_PREP;
         S_PREP:  state_in = (dd[1:0] == 2'd0) ? S_BUILD : S_OUT;
         S_BUILD: if (k_ff == IDX_W'(ROW_SLOTS - 1)) state_in = S_CHECK;
         S_CHECK: begin
            if (infeas_ff || parts_ff.lam[2] > parts_ff.lam[1] ||
                parts_ff.nu[2] > parts_ff.nu[1]) begin
               state_in = S_OUT;
            end else begin
               state_in = S_START;
            end
         end
         S_START: state_in = S_FIBRE;
         S_FIBRE: if (k_ff == IDX_W'(ROW_SLOTS - 1)) state_in = S_ACC;
         S_ACC: begin
            if (v_ff < vhi_ff || u_ff < uhi_ff) begin
               state_in = S_FIBRE;
            end else if (n_ff == DIL_W'(1) && acc_total == '0) begin
               state_in = S_OUT;
            end else if (n_ff < DIL_W'(DILATIONS)) begin
               state_in = S_START;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN:   state_in = S_CLAMP;
         S_CLAMP: state_in = S_OUT;
         S_OUT:   if (rsp_chan.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_chan.ready = (state_ff == S_IDLE);
      rsp_chan.valid = (state_ff == S_OUT);
      rsp_chan.valid_res        = rv_ff;
      rsp_chan.status           = st_ff;
      rsp_chan.count_1          = cnt_ff[0];
      rsp_chan.count_2          = cnt_ff[1];
      rsp_chan.count_3          = cnt_ff[2];
      rsp_chan.six_linear_coeff = six_ff[COEF_W-1:0];
      rsp_chan.volume           = vol_ff[COEF_W-1:0];
   end

   // datapath next values
   always_comb begin
      g_in      = g_ff;
      parts_in  = parts_ff;
      infeas_in = infeas_ff;
      rhs_in    = row_rhs;
      rhs_we    = 1'b0;
      k_in      = k_ff;
      n_in      = n_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      uhi_in    = uhi_ff;
      vlo_in    = vlo_ff;
      vhi_in    = vhi_ff;
      trk_in    = trk_ff;
      total_in  = total_ff;
      rv_in     = rv_ff;
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      six_in    = six_ff;
      vol_in    = vol_ff;
      case (state_ff)
         S_IDLE: begin
            g_in[0] = req_chan.lam_gap_1;
            g_in[1] = req_chan.lam_gap_2;
            g_in[2] = req_chan.lam_gap_3;
            g_in[3] = req_chan.mu_gap_1;
            g_in[4] = req_chan.mu_gap_2;
            g_in[5] = req_chan.mu_gap_3;
            g_in[6] = req_chan.nu_gap_1;
            g_in[7] = req_chan.nu_gap_2;
            g_in[8] = req_chan.nu_gap_3;
         end
         S_PREP: begin
            parts_in  = parts_calc;
            infeas_in = 1'b0;
            k_in      = '0;
            rv_in     = 1'b0;
            st_in     = ST_NOT_DIV;
            six_in    = '0;
            vol_in    = '0;
            for (int i = 0; i < DILATIONS; i++) cnt_in[i] = '0;
         end
         S_BUILD: begin
            rhs_we    = 1'b1;
            infeas_in = infeas_ff | row_infeas;
            k_in      = (k_ff == IDX_W'(ROW_SLOTS - 1)) ? '0 : k_ff + 1'b1;
         end
         S_CHECK: begin
            n_in = DIL_W'(1);
            if (infeas_ff) begin
               st_in  = ST_INFEAS;
               six_in = -42'sd11;
               vol_in = -42'sd1;
            end else begin
               st_in = ST_EMPTY_RANGE;
            end
         end
         S_START: begin
            u_in      = ulo_n;
            v_in      = vlo_n;
            uhi_in    = uhi_n;
            vlo_in    = vlo_n;
            vhi_in    = vhi_n;
            k_in      = '0;
            total_in  = '0;
            trk_in    = '{lo: '0, hi: '0, lo_inf: 1'b1, hi_inf: 1'b1, ok: 1'b1};
         end
         S_FIBRE: begin
            trk_in = trk_eval;
            k_in   = (k_ff == IDX_W'(ROW_SLOTS - 1)) ? '0 : k_ff + 1'b1;
         end
         S_ACC: begin
            total_in = acc_total;
            trk_in   = '{lo: '0, hi: '0, lo_inf: 1'b1, hi_inf: 1'b1, ok: 1'b1};
            k_in     = '0;
            if (v_ff < vhi_ff) begin
               v_in = v_ff + 1'b1;
            end else if (u_ff < uhi_ff) begin
               u_in = u_ff + 1'b1;
               v_in = vlo_ff;
            end else begin
               // dilation done
               cnt_in[n_ff - DIL_W'(1)] = acc_total;
               if (n_ff == DIL_W'(1) && acc_total == '0) begin
                  st_in = ST_EMPTY_POLY;
               end else begin
                  n_in = n_ff + 1'b1;
               end
            end
         end
         S_FIN: begin
            six_in = -42'sd11 + 42'sd18 * c1w - 42'sd9 * c2w + 42'sd2 * c3w;
            vol_in = c3w - 42'sd3 * c2w + 42'sd3 * c1w - 42'sd1;
         end
         S_CLAMP: begin
            rv_in = 1'b1;
            st_in = ST_OK;
            if (six_ff > COEF_LIM) six_in = COEF_LIM;
            else if (six_ff < -COEF_LIM) six_in = -COEF_LIM;
            if (vol_ff > COEF_LIM) vol_in = COEF_LIM;
            else if (vol_ff < -42'sd1) vol_in = -42'sd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff      <= g_in;
      parts_ff  <= parts_in;
      infeas_ff <= infeas_in;
      if (rhs_we) rhs_ff[k_ff] <= rhs_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      uhi_ff    <= uhi_in;
      vlo_ff    <= vlo_in;
      vhi_ff    <= vhi_in;
      trk_ff    <= trk_in;
      total_ff  <= total_in;
      rv_ff     <= rv_in;
      st_ff     <= st_in;
      cnt_ff    <= cnt_in;
      six_ff    <= six_in;
      vol_ff    <= vol_in;
   end

endmodule
`default_nettype wire
